[rtl/hcc_pkg.sv]
package hcc_pkg;

  // bits carried by one code block
  localparam int GROUP_BITS = 11;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // parity coverage masks, one per syndrome bit
  localparam logic [15:0] AREA_MASK [4] = '{16'h5555, 16'h3333, 16'h0F0F, 16'h00FF};

  // data bit positions within a block, counted from the msb
  localparam int DATA_POS [GROUP_BITS] = '{3, 5, 6, 7, 9, 10, 11, 12, 13, 14, 15};

  // hamming parity positions, counted from the msb
  localparam int PAR_POS [4] = '{1, 2, 4, 8};

  // one queue entry: up to two results of one input item
  typedef struct packed {
    logic        mode;      // 1 when the values are decoded bytes
    logic        two;       // entry holds two results
    logic        msg_end;   // input item closed its message
    logic [15:0] val0;
    logic [15:0] val1;
  } hcc_entry_t;

  // place 11 data bits and add hamming and overall parity
  function automatic logic [15:0] encode_group(input logic [GROUP_BITS-1:0] grp);
    logic [15:0] blk;
    blk = '0;
    for (int i = 0; i < GROUP_BITS; i++) begin
      blk[15 - DATA_POS[i]] = grp[GROUP_BITS - 1 - i];
    end
    for (int x = 0; x < 4; x++) begin
      if (^(blk & AREA_MASK[x])) begin
        blk[15 - PAR_POS[x]] = 1'b1;
      end
    end
    if (^blk) begin
      blk[15] = 1'b1;
    end
    return blk;
  endfunction

  // repair a single error when overall parity is odd, then extract data
  function automatic logic [GROUP_BITS-1:0] decode_block(input logic [15:0] blk_in);
    logic [15:0]           blk;
    logic [15:0]           flip;
    logic [GROUP_BITS-1:0] data;
    blk  = blk_in;
    flip = '1;
    data = '0;
    if (^blk) begin
      for (int x = 0; x < 4; x++) begin
        if (^(blk & AREA_MASK[x])) begin
          flip = flip & AREA_MASK[x];
        end else begin
          flip = flip & ~AREA_MASK[x];
        end
      end
      blk = blk ^ flip;
    end
    for (int i = 0; i < GROUP_BITS; i++) begin
      data[GROUP_BITS - 1 - i] = blk[15 - DATA_POS[i]];
    end
    return data;
  endfunction

endpackage

[rtl/hcc_front.sv]
module hcc_front
  import hcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_fire,
  input  logic [7:0]  data_byte,
  input  logic [15:0] code_block,
  input  logic        message_end,
  output logic        push_valid,
  output hcc_entry_t  push_entry
);

  logic        mode_r;
  logic [9:0]  acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [17:0] acc_w;
  logic [4:0]  sum;
  logic        full_e;
  logic [4:0]  rem_e;
  logic [17:0] acc_e;
  logic [GROUP_BITS-1:0] g_full, g_pad;
  logic        pad_e;
  logic [15:0] blk_full, blk_pad;
  logic [GROUP_BITS-1:0] dec_data;
  logic [4:0]  rem1, rem2, rem_d;
  logic        two_d;
  logic [17:0] acc_d;
  logic [7:0]  byte1, byte2;
  logic [17:0] acc_n18;
  logic [4:0]  cnt_n5;

  // repair and extract the data bits of the received block
  assign dec_data = decode_block(code_block);

  // gearbox: append the new bits and cut off whole groups
  always_comb begin
    acc_w    = '0;
    sum      = '0;
    full_e   = 1'b0;
    rem_e    = '0;
    acc_e    = '0;
    g_full   = '0;
    g_pad    = '0;
    pad_e    = 1'b0;
    rem1     = '0;
    rem2     = '0;
    rem_d    = '0;
    two_d    = 1'b0;
    acc_d    = '0;
    byte1    = '0;
    byte2    = '0;
    if (!mode_r) begin
      acc_w  = {acc_r, data_byte};
      sum    = 5'(cnt_r) + 5'd8;
      full_e = (sum >= 5'd11);
      rem_e  = full_e ? (sum - 5'd11) : sum;
      g_full = GROUP_BITS'(acc_w >> rem_e);
      acc_e  = acc_w & ((18'(1) << rem_e) - 18'd1);
      pad_e  = message_end && (rem_e != 5'd0);
      g_pad  = GROUP_BITS'(acc_e << (5'd11 - rem_e));
    end else begin
      acc_w  = {acc_r[6:0], dec_data};
      sum    = 5'(cnt_r) + 5'd11;
      rem1   = sum - 5'd8;
      byte1  = 8'(acc_w >> rem1);
      two_d  = (rem1 >= 5'd8);
      rem2   = rem1 - 5'd8;
      byte2  = 8'(acc_w >> rem2);
      rem_d  = two_d ? rem2 : rem1;
      acc_d  = acc_w & ((18'(1) << rem_d) - 18'd1);
    end
  end

  // parity generation for the full and the padded group
  assign blk_full = encode_group(g_full);
  assign blk_pad  = encode_group(g_pad);

  // build the queue entry
  always_comb begin
    push_entry.mode    = mode_r;
    push_entry.msg_end = message_end;
    if (!mode_r) begin
      push_entry.two  = full_e && pad_e;
      push_entry.val0 = full_e ? blk_full : blk_pad;
      push_entry.val1 = blk_pad;
      push_valid      = in_fire && (full_e || pad_e);
      acc_n18         = acc_e;
      cnt_n5          = rem_e;
    end else begin
      push_entry.two  = two_d;
      push_entry.val0 = {8'h00, byte1};
      push_entry.val1 = {8'h00, byte2};
      push_valid      = in_fire;
      acc_n18         = acc_d;
      cnt_n5          = rem_d;
    end
    if (message_end) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end else begin
      acc_nxt = acc_n18[9:0];
      cnt_nxt = cnt_n5[3:0];
    end
  end

  // mode register and gearbox state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (in_fire) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // encode never holds a full group
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd10)
    else $error("gearbox count out of range");

  // decode never holds a whole byte
  a_dec_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> cnt_r < 4'd8)
    else $error("decode gearbox holds a whole byte");

  // a closed message leaves the gearbox empty
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && message_end && !cfg_we) |=> (cnt_r == 4'd0))
    else $error("gearbox not cleared at message end");
`endif

endmodule

[rtl/hcc_queue.sv]
module hcc_queue
  import hcc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  hcc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output hcc_entry_t head_entry,
  output logic       empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hcc_entry_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // fill count tracks the pointer distance
  a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

[rtl/hcc_back.sv]
module hcc_back
  import hcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  hcc_entry_t  head_entry,
  input  logic        empty,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic        sel_r;
  logic [15:0] cur;
  logic        last_beat;
  logic        fire;

  // pick the current result of the head entry
  assign cur        = sel_r ? head_entry.val1 : head_entry.val0;
  assign last_beat  = !head_entry.two || sel_r;
  assign out_tvalid = !empty;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && last_beat;

  // format the beat for the active mode
  assign out_tdata = head_entry.mode ? {cur[7:0], 16'h0000} : {8'h00, cur};
  assign out_tuser = last_beat;
  assign out_tlast = last_beat && head_entry.msg_end;

  // step to the second result of a two-result entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (fire) begin
      sel_r <= !last_beat;
    end
  end

`ifndef SYNTHESIS
  // second beat only exists for a waiting two-result entry
  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!empty && head_entry.two))
    else $error("second beat selected without a two-result entry");
`endif

endmodule

[rtl/hamming_16_11_stream_codec.sv]
// a result beat is stored in the queue when its input beat is accepted and offered from the queue head
// one input beat per cycle in encode while the queue is not full; decode turns each
//   beat into 11 data bits and can emit two byte beats for one input beat, and the
//   queue of QUEUE_DEPTH entries absorbs shorter bursts and output stalls
// in_tready drops only while the queue is full
// reset (rst_n low, synchronous): encode mode, gearbox empty, queue empty
module hamming_16_11_stream_codec
  import hcc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // decode_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // data_byte[7:0], code_block[23:8]
  input  logic        in_tlast,      // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // block_out[15:0], byte_out[23:16]
  output logic        out_tuser,     // run_last
  output logic        out_tlast      // message_done
);

  logic       in_fire;
  logic       push_valid;
  hcc_entry_t push_entry;
  hcc_entry_t head_entry;
  logic       q_full, q_empty, q_pop;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // accept and gearbox
  hcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .data_byte   (in_tdata[7:0]),
    .code_block  (in_tdata[23:8]),
    .message_end (in_tlast),
    .push_valid  (push_valid),
    .push_entry  (push_entry)
  );

  // decoupling queue
  hcc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  // result beat sequencer
  hcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
